[design/swr_pkg.sv]
// ----------------------------------------------------------------------------
// swr_pkg
// Shared sizes, request codes and internal bundles of the value-removal stack.
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WIDE_W  = CNT_W + 1;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_PEEK   = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;
  localparam logic [1:0] MODE_REMOVE = 2'd3;

  // one write and one read access to the entry store per cycle
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic                      ok;
    logic signed [DATA_W-1:0]  data_out;
    logic        [COUNT_W-1:0] count;
  } result_t;

endpackage

[design/swr_req_if.sv]
// ----------------------------------------------------------------------------
// swr_req_if
// Request channel: valid/ready handshake carrying mode and value.
// ----------------------------------------------------------------------------
interface swr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

[design/swr_rsp_if.sv]
// ----------------------------------------------------------------------------
// swr_rsp_if
// Result channel: valid/ready handshake carrying ok, data_out and count.
// ----------------------------------------------------------------------------
interface swr_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] data_out;
  logic [4:0]         count;

  modport source (output valid, output ok, output data_out, output count, input ready);
  modport sink   (input valid, input ok, input data_out, input count, output ready);
endinterface

[design/stack_with_remove_by_value_core.sv]
// ----------------------------------------------------------------------------
// stack_with_remove_by_value_core
// Bounded LIFO stack of signed 32-bit values with removal of the topmost match.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered with one result. A push
// writes the new entry in IDLE; a peek or pop reads the top entry, whose
// data is taken from the store in RD_WAIT. A removal examines entries from
// the top down to the match (all held entries on a miss), then slides each
// entry above the match down one place. The sequencer uses the single read
// port of the entry store one entry per cycle. A result waits in an output
// register, so the next request is taken while it is pending.
module stack_with_remove_by_value_core
  import swr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  swr_req_if.sink   req,
  swr_rsp_if.source rsp
);

  ram_req_t          ram;
  logic [DATA_W-1:0] rdata;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              out_valid;
  result_t           out_res;

  swr_ram u_ram (
    .clk   (clk),
    .req   (ram),
    .rdata (rdata)
  );

  swr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ram       (ram),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // load the output register when it is empty or drains this cycle
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.ok       = out_res.ok;
  assign rsp.data_out = out_res.data_out;
  assign rsp.count    = out_res.count;

endmodule

[design/swr_ram.sv]
// ----------------------------------------------------------------------------
// swr_ram
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swr_ram
  import swr_pkg::*;
(
  input  logic              clk,
  input  ram_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

[design/swr_ctrl.sv]
// ----------------------------------------------------------------------------
// swr_ctrl
// Request sequencer: drives the entry store with one write and one read access
// a cycle, walks down from the top for a match and closes the gap one entry a cycle.
// ----------------------------------------------------------------------------
module swr_ctrl
  import swr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  swr_req_if.sink           req,
  output ram_req_t          ram,
  input  logic [DATA_W-1:0] rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  typedef enum logic [2:0] {IDLE, RD_WAIT, SRCH, SHIFT, DONE} state_t;

  state_t             state;
  logic [1:0]         mode;
  logic [DATA_W-1:0]  value;
  logic [IDX_W-1:0]   pos;
  logic [CNT_W-1:0]   fill;
  logic               ok;
  logic [DATA_W-1:0]  data;

  logic [WIDE_W-1:0]  pos_w;
  logic [WIDE_W-1:0]  fill_w;
  logic               above1;
  logic               above2;
  logic               hit;
  logic               full;

  assign pos_w  = WIDE_W'(pos);
  assign fill_w = WIDE_W'(fill);
  assign above1 = (pos_w + WIDE_W'(1)) < fill_w;
  assign above2 = (pos_w + WIDE_W'(2)) < fill_w;
  assign hit    = (rdata == value);
  assign full   = (fill >= CNT_W'(DEPTH));

  assign req.ready = (state == IDLE);
  assign res_valid = (state == DONE);
  assign res.ok       = ok;
  assign res.data_out = $signed(data);
  assign res.count    = COUNT_W'(fill);

  always_comb begin
    ram = '0;
    case (state)
      IDLE: begin
        if (req.valid) begin
          case (req.mode)
            MODE_PUSH: begin
              ram.we    = !full;
              ram.waddr = IDX_W'(fill);
              ram.wdata = $unsigned(req.value);
            end
            default: begin
              ram.re    = (fill != '0);
              ram.raddr = IDX_W'(fill - CNT_W'(1));
            end
          endcase
        end
      end
      SRCH: begin
        if (hit) begin
          ram.re    = above1;
          ram.raddr = IDX_W'(pos_w + WIDE_W'(1));
        end else begin
          ram.re    = (pos != '0);
          ram.raddr = pos - IDX_W'(1);
        end
      end
      SHIFT: begin
        // move the entry above down into the gap, fetch the next one
        ram.we    = 1'b1;
        ram.waddr = pos;
        ram.wdata = rdata;
        ram.re    = above2;
        ram.raddr = IDX_W'(pos_w + WIDE_W'(2));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      fill  <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (req.valid) begin
            mode  <= req.mode;
            value <= $unsigned(req.value);
            ok    <= 1'b0;
            data  <= '0;
            case (req.mode)
              MODE_PUSH: begin
                if (!full) begin
                  fill <= fill + CNT_W'(1);
                  ok   <= 1'b1;
                end
                state <= DONE;
              end
              MODE_PEEK, MODE_POP: begin
                state <= (fill != '0) ? RD_WAIT : DONE;
              end
              default: begin
                pos   <= IDX_W'(fill - CNT_W'(1));
                state <= (fill != '0) ? SRCH : DONE;
              end
            endcase
          end
        end
        RD_WAIT: begin
          data <= rdata;
          ok   <= 1'b1;
          if (mode == MODE_POP) begin
            fill <= fill - CNT_W'(1);
          end
          state <= DONE;
        end
        SRCH: begin
          if (hit) begin
            if (above1) begin
              state <= SHIFT;
            end else begin
              fill  <= fill - CNT_W'(1);
              ok    <= 1'b1;
              state <= DONE;
            end
          end else if (pos == '0) begin
            state <= DONE;
          end else begin
            pos <= pos - IDX_W'(1);
          end
        end
        SHIFT: begin
          pos <= pos + IDX_W'(1);
          if (!above2) begin
            fill  <= fill - CNT_W'(1);
            ok    <= 1'b1;
            state <= DONE;
          end
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE && req.valid && req.mode == MODE_PUSH && !full)
    |=> (fill == $past(fill) + CNT_W'(1)))
    else $error("accepted push did not grow the stack");

  a_search_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == SRCH) |-> (pos_w < fill_w))
    else $error("search position outside stored entries");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == SHIFT) |-> above1)
    else $error("shift reads beyond the top");

  a_data_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (state == DONE && data != '0) |-> ok)
    else $error("data returned on a failed request");

endmodule
